>>> rtl/core/drs_pkg.sv
// Shared types and constants for the dictionary range scan block.
`timescale 1ns / 1ps
`default_nettype none

package drs_pkg;

  // Fixed field widths
  localparam int DATA_W    = 64;
  localparam int GROUP_W   = 64;
  localparam int COUNT_W   = 4;
  localparam int CFG_IDX_W = 1;

  // Parameter defaults
  localparam int CODE_BITS_DEF = 8;
  localparam int LANES_DEF     = 8;

  // Item opcodes
  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_SCAN = 1'b1
  } drs_op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_LOW  = 1'b0,
    REG_RANGE_HIGH = 1'b1
  } drs_reg_t;

  // One lane read issued by the sequencer
  typedef struct packed {
    logic rd_en;      // dictionary read this cycle
    logic group_end;  // read is the last lane of its group
  } drs_issue_t;

endpackage

`default_nettype wire

>>> rtl/core/drs_dict_mem.sv
// Dictionary storage: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module drs_dict_mem #(
  parameter int ADDR_W = 8,
  parameter int WORD_W = 64
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WORD_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WORD_W-1:0] rd_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, old data on a same-address write; holds when not reading
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/core/drs_lane_seq.sv
// Input item intake and per-lane dictionary read sequencing.
`timescale 1ns / 1ps
`default_nettype none

module drs_lane_seq
  import drs_pkg::*;
#(
  parameter int CODE_BITS = CODE_BITS_DEF,
  parameter int LANES     = LANES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_opcode,
  input  wire logic [CODE_BITS-1:0] in_entry_index,
  input  wire logic [DATA_W-1:0]    in_entry_value,
  input  wire logic [GROUP_W-1:0]   in_code_group,
  input  wire logic [COUNT_W-1:0]   in_code_count,
  input  wire logic                 b_free,
  output drs_issue_t                issue,
  output logic [CODE_BITS-1:0]      rd_addr,
  output logic                      wr_en,
  output logic [CODE_BITS-1:0]      wr_addr,
  output logic [DATA_W-1:0]         wr_data
);

  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

  logic                 active_r, active_nxt;
  logic [LANE_W-1:0]    lane_r, lane_nxt;
  logic [LANE_W-1:0]    last_r, last_nxt;
  logic [CODE_BITS-1:0] codes_r   [LANES];
  logic [CODE_BITS-1:0] codes_nxt [LANES];
  logic [CODE_BITS-1:0] lane_codes [LANES];
  logic [COUNT_W-1:0]   eff_count;
  logic                 rd_go, at_last, accept, scan_acc;

  // Split the code word into lanes; bits above the word read as zero
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    for (genvar b = 0; b < CODE_BITS; b++) begin : g_bit
      if (CODE_BITS * k + b < GROUP_W) begin : g_in
        assign lane_codes[k][b] = in_code_group[CODE_BITS * k + b];
      end else begin : g_zero
        assign lane_codes[k][b] = 1'b0;
      end
    end
  end

  // Handshake and read issue
  assign eff_count = (in_code_count > COUNT_W'(LANES)) ? COUNT_W'(LANES) : in_code_count;
  assign rd_go     = active_r && b_free;
  assign at_last   = (lane_r == last_r);
  assign in_ready  = !active_r || (rd_go && at_last);
  assign accept    = in_valid && in_ready;
  assign scan_acc  = accept && (drs_op_t'(in_opcode) == OP_SCAN) && (in_code_count != '0);

  assign issue.rd_en     = rd_go;
  assign issue.group_end = at_last;
  assign rd_addr         = codes_r[0];

  // Load items write straight into the dictionary
  assign wr_en   = accept && (drs_op_t'(in_opcode) == OP_LOAD);
  assign wr_addr = in_entry_index;
  assign wr_data = in_entry_value;

  // Lane walk: codes shift down one lane per read
  always_comb begin
    active_nxt = active_r;
    lane_nxt   = lane_r;
    last_nxt   = last_r;
    codes_nxt  = codes_r;
    if (rd_go) begin
      if (at_last) begin
        active_nxt = 1'b0;
      end else begin
        lane_nxt = lane_r + 1'b1;
        for (int k = 0; k < LANES - 1; k++) begin
          codes_nxt[k] = codes_r[k + 1];
        end
      end
    end
    if (scan_acc) begin
      active_nxt = 1'b1;
      lane_nxt   = '0;
      last_nxt   = LANE_W'(eff_count - 1'b1);
      codes_nxt  = lane_codes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lane_r  <= lane_nxt;
    last_r  <= last_nxt;
    codes_r <= codes_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/core/drs_match_emit.sv
// Range compare, last-match lookahead and result output register.
`timescale 1ns / 1ps
`default_nettype none

module drs_match_emit
  import drs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_wdata,
  input  drs_issue_t                issue,
  input  wire logic [DATA_W-1:0]    rd_data,
  output logic                      b_free,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [DATA_W-1:0]         out_match_value,
  output logic                      out_last_match
);

  logic signed [DATA_W-1:0] range_low_r, range_high_r;

  // Read-data stage tag
  logic b_valid_r, b_end_r;
  // Compare stage
  logic              c_valid_r, c_match_r, c_end_r;
  logic [DATA_W-1:0] c_val_r;
  // Pending match: held until a later match or the group end settles last
  logic              p_valid_r, p_valid_nxt, p_last_r, p_last_nxt;
  logic [DATA_W-1:0] p_val_r, p_val_nxt;
  // Output register
  logic              o_valid_r, o_last_r;
  logic [DATA_W-1:0] o_val_r;

  logic o_free, p_move, c_take, c_free, b_take, hit;

  // Range registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= '0;
      range_high_r <= '0;
    end else if (cfg_we) begin
      unique case (drs_reg_t'(cfg_index))
        REG_RANGE_LOW:  range_low_r  <= cfg_wdata;
        REG_RANGE_HIGH: range_high_r <= cfg_wdata;
      endcase
    end
  end

  // Stage flow control
  assign o_free = !o_valid_r || out_ready;
  assign p_move = p_valid_r && o_free && (p_last_r || (c_valid_r && c_match_r));
  assign c_take = c_valid_r && (!c_match_r || !p_valid_r || p_move);
  assign c_free = !c_valid_r || c_take;
  assign b_take = b_valid_r && c_free;
  assign b_free = !b_valid_r || b_take;

  assign hit = ($signed(rd_data) >= range_low_r) && ($signed(rd_data) <= range_high_r);

  // Pending slot update
  always_comb begin
    p_valid_nxt = p_valid_r && !p_move;
    p_last_nxt  = p_last_r;
    p_val_nxt   = p_val_r;
    if (c_take) begin
      if (c_match_r) begin
        p_valid_nxt = 1'b1;
        p_last_nxt  = c_end_r;
        p_val_nxt   = c_val_r;
      end else if (c_end_r) begin
        p_last_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      p_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (issue.rd_en) begin
        b_valid_r <= 1'b1;
      end else if (b_take) begin
        b_valid_r <= 1'b0;
      end
      if (b_take) begin
        c_valid_r <= 1'b1;
      end else if (c_take) begin
        c_valid_r <= 1'b0;
      end
      p_valid_r <= p_valid_nxt;
      if (p_move) begin
        o_valid_r <= 1'b1;
      end else if (out_ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (issue.rd_en) begin
      b_end_r <= issue.group_end;
    end
    if (b_take) begin
      c_val_r   <= rd_data;
      c_match_r <= hit;
      c_end_r   <= b_end_r;
    end
    p_last_r <= p_last_nxt;
    p_val_r  <= p_val_nxt;
    if (p_move) begin
      o_val_r  <= p_val_r;
      o_last_r <= p_last_r;
    end
  end

  assign out_valid       = o_valid_r;
  assign out_match_value = o_val_r;
  assign out_last_match  = o_last_r;

endmodule

`default_nettype wire

>>> rtl/core/dictionary_range_scan_top.sv
// Dictionary range scan: top level with dictionary, sequencer and emitter.
//
// Input channel (in_valid/in_ready): opcode load writes in_entry_value into
// dictionary slot in_entry_index; opcode scan carries up to LANES codes in
// in_code_group, in_code_count of them valid from lane 0 (saturated to LANES).
// Each valid lane is decoded through the dictionary; values inside the signed
// window [range_low, range_high] leave on the result channel in lane order,
// the final one of the group flagged by out_last_match. No match, no result.
// Config: cfg_we writes cfg_wdata into register cfg_index (0 low, 1 high);
// write only while idle.
// Throughput: one lane read per cycle from the single dictionary read port
// while the read-data stage has room; a load is taken on the cycle the
// previous scan issues its last read.
// Results pass the read-data, compare, pending and output registers in turn;
// a lane's result is held back until the next match or the end of its group
// is seen, so last_match is known when it leaves.
// Reset clears control state and both range registers; the dictionary is
// not cleared and must be loaded before it is scanned.
// Receiver stall: the output register and pending slot hold, the read
// pipeline backs up, and in_ready drops once the sequencer cannot issue.
`timescale 1ns / 1ps
`default_nettype none

module dictionary_range_scan_top
  import drs_pkg::*;
#(
  parameter int CODE_BITS = CODE_BITS_DEF,
  parameter int LANES     = LANES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_opcode,
  input  wire logic [CODE_BITS-1:0] in_entry_index,
  input  wire logic [DATA_W-1:0]    in_entry_value,
  input  wire logic [GROUP_W-1:0]   in_code_group,
  input  wire logic [COUNT_W-1:0]   in_code_count,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [DATA_W-1:0]         out_match_value,
  output logic                      out_last_match
);

  drs_issue_t           issue;
  logic                 b_free;
  logic [CODE_BITS-1:0] rd_addr, wr_addr;
  logic [DATA_W-1:0]    rd_data, wr_data;
  logic                 mem_we;

  drs_lane_seq #(
    .CODE_BITS(CODE_BITS),
    .LANES    (LANES)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_entry_index(in_entry_index),
    .in_entry_value(in_entry_value),
    .in_code_group (in_code_group),
    .in_code_count (in_code_count),
    .b_free        (b_free),
    .issue         (issue),
    .rd_addr       (rd_addr),
    .wr_en         (mem_we),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  drs_dict_mem #(
    .ADDR_W(CODE_BITS),
    .WORD_W(DATA_W)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (issue.rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  drs_match_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .issue          (issue),
    .rd_data        (rd_data),
    .b_free         (b_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_match_value(out_match_value),
    .out_last_match (out_last_match)
  );

  // A read is only issued when the read-data stage can take it
  a_issue_room: assert property (@(posedge clk) disable iff (!rst_n)
    issue.rd_en |-> b_free)
    else $error("lane read issued with read stage full");

  // A load may overlap a scan only on that scan's final lane read
  a_load_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && issue.rd_en) |-> issue.group_end)
    else $error("dictionary write overlaps pending lane reads");

  // Output is empty right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire
